FILE: hdl/idw_pkg.sv
// ---------------------------------------------------------------------------
// idw_pkg: shared types and constants for the inverse distance weights core
// Holds the row and result payload structs, the sequencer states and the
// widths of the weight store, the column sums and the shared divider.
// ---------------------------------------------------------------------------
package idw_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int NCOLS     = 4;
    localparam int COL_W     = 2;
    localparam int DIST_W    = 32;
    localparam int RAW_W     = 48;
    localparam int WEIGHT_W  = 17;

    localparam int ROW_IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_W      = $clog2(MAX_ROWS + 1);
    localparam int SUM_W      = RAW_W + ROW_W;
    localparam int RAM_DEPTH  = MAX_ROWS * NCOLS;
    localparam int RAM_ADDR_W = ROW_IDX_W + COL_W;

    // Shared restoring divider: 49 quotient bits for the reciprocal of a
    // distance, 17 for a normalised weight.
    localparam int QUO_W       = RAW_W + 1;
    localparam int CNT_W       = $clog2(QUO_W);
    localparam int RECIP_STEPS = QUO_W;
    localparam int NORM_STEPS  = WEIGHT_W;

    localparam logic [RAW_W-1:0]    RAW_MAX    = {RAW_W{1'b1}};
    localparam logic [RAW_W-1:0]    RAW_ONE    = RAW_W'(64'd1 << 32);
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(32'd65536);
    localparam logic [DIST_W-1:0]   MIN_DIST_RESET = DIST_W'(1);

    typedef struct packed {
        logic [DIST_W-1:0] dist_euclid;
        logic [DIST_W-1:0] dist_x;
        logic [DIST_W-1:0] dist_y;
        logic [DIST_W-1:0] dist_z;
        logic              last_row;
    } t_row;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_euclid;
        logic [WEIGHT_W-1:0] weight_x;
        logic [WEIGHT_W-1:0] weight_y;
        logic [WEIGHT_W-1:0] weight_z;
        logic                final_weight_row;
    } t_weights;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COL,
        S_RDIV,
        S_NREAD,
        S_NLOAD,
        S_NDIV,
        S_CEMIT
    } t_state;

endpackage

FILE: hdl/idw_ram.sv
// ---------------------------------------------------------------------------
// idw_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module idw_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/inverse_distance_weights_core.sv
// ---------------------------------------------------------------------------
// inverse_distance_weights_core: Shepard weights (exponent 1) per neighbour set
// A row is accepted while idle; each column whose distance exceeds
// min_distance then takes a 49-step reciprocal on the shared divider, and
// any other column takes the raw weight of one. On the last row each result
// needs four normalising divisions, or none at all for a coincident set.
// Throughput is one row at a time, bounded by the single shared divider.
// Reset (synchronous, active low) clears the set and sets min_distance to 1.
// Results are one-cycle strobes; the receiver cannot stall them.
// ---------------------------------------------------------------------------
module inverse_distance_weights_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  idw_pkg::t_row                     i_cmd,
    output idw_pkg::t_weights                 o_res,
    output logic                              o_res_strobe,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [idw_pkg::DIST_W-1:0]        i_cfg_data
);

    // -----------------------------------------------------------------------
    // Registers. Control state is reset; the datapath registers are loaded
    // before every use and carry no reset.
    // -----------------------------------------------------------------------
    idw_pkg::t_state                       r_state,  n_state;
    logic [idw_pkg::DIST_W-1:0]            r_min,    n_min;
    logic [idw_pkg::ROW_W-1:0]             r_count,  n_count;
    logic                                  r_coinc,  n_coinc;
    logic [idw_pkg::SUM_W-1:0]             r_sum [idw_pkg::NCOLS];
    logic [idw_pkg::SUM_W-1:0]             n_sum [idw_pkg::NCOLS];
    logic                                  r_strobe, n_strobe;

    logic [idw_pkg::DIST_W-1:0]            r_d   [idw_pkg::NCOLS];
    logic [idw_pkg::DIST_W-1:0]            n_d   [idw_pkg::NCOLS];
    logic                                  r_last,   n_last;
    logic [idw_pkg::COL_W-1:0]             r_col,    n_col;
    logic [idw_pkg::ROW_IDX_W-1:0]         r_row,    n_row;
    logic [idw_pkg::CNT_W-1:0]             r_cnt,    n_cnt;
    logic [idw_pkg::SUM_W-1:0]             r_div,    n_div;
    logic [idw_pkg::SUM_W-1:0]             r_rem,    n_rem;
    logic                                  r_inbit,  n_inbit;
    logic [idw_pkg::QUO_W-1:0]             r_q,      n_q;
    logic [idw_pkg::WEIGHT_W-1:0]          r_w   [idw_pkg::NCOLS];
    logic [idw_pkg::WEIGHT_W-1:0]          n_w   [idw_pkg::NCOLS];
    idw_pkg::t_weights                     r_res,    n_res;

    // Weight store write and read ports.
    logic                                  ram_we;
    logic [idw_pkg::RAM_ADDR_W-1:0]        ram_waddr;
    logic [idw_pkg::RAW_W-1:0]             ram_wdata;
    logic [idw_pkg::RAM_ADDR_W-1:0]        ram_raddr;
    logic [idw_pkg::RAW_W-1:0]             ram_rdata;

    // -----------------------------------------------------------------------
    // Shared restoring divider step. The partial remainder is shifted left
    // with the next dividend bit, compared with the divisor and reduced when
    // it is not smaller. A reciprocal starts from a zero remainder with the
    // single set bit of 2^48 as the first dividend bit. A normalisation
    // divides raw * 2^16 by the column sum; as the quotient is known to stay
    // below 2^17, its leading zero quotient bits leave raw >> 1 as the
    // remainder, so the step starts there with raw[0] as the first bit.
    // -----------------------------------------------------------------------
    logic [idw_pkg::SUM_W:0]               step_t;
    logic [idw_pkg::SUM_W:0]               step_diff;
    logic                                  step_ge;
    logic [idw_pkg::SUM_W-1:0]             step_rem;
    logic [idw_pkg::QUO_W-1:0]             step_q;
    logic [idw_pkg::RAW_W-1:0]             recip_raw;
    logic [idw_pkg::WEIGHT_W-1:0]          norm_w;

    assign step_t    = {r_rem, r_inbit};
    assign step_ge   = step_t >= {1'b0, r_div};
    assign step_diff = step_t - {1'b0, r_div};
    assign step_rem  = step_ge ? step_diff[idw_pkg::SUM_W-1:0] : step_t[idw_pkg::SUM_W-1:0];
    assign step_q    = {r_q[idw_pkg::QUO_W-2:0], step_ge};

    // A distance of one Q16.16 step gives exactly 2^48, which saturates.
    assign recip_raw = step_q[idw_pkg::QUO_W-1] ? idw_pkg::RAW_MAX
                                                : step_q[idw_pkg::RAW_W-1:0];

    // An empty column sum cannot occur with a stored row, but it reads as zero.
    always_comb begin
        if (r_div == '0) begin
            norm_w = '0;
        end else if (step_q[idw_pkg::WEIGHT_W-1:0] > idw_pkg::WEIGHT_ONE) begin
            norm_w = idw_pkg::WEIGHT_ONE;
        end else begin
            norm_w = step_q[idw_pkg::WEIGHT_W-1:0];
        end
    end

    assign ram_raddr = {r_row, r_col};

    idw_ram #(
        .WIDTH  (idw_pkg::RAW_W),
        .DEPTH  (idw_pkg::RAM_DEPTH),
        .ADDR_W (idw_pkg::RAM_ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // -----------------------------------------------------------------------
    // State registers.
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= idw_pkg::S_IDLE;
            r_min    <= idw_pkg::MIN_DIST_RESET;
            r_count  <= '0;
            r_coinc  <= 1'b0;
            r_strobe <= 1'b0;
            for (int c = 0; c < idw_pkg::NCOLS; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_min    <= n_min;
            r_count  <= n_count;
            r_coinc  <= n_coinc;
            r_strobe <= n_strobe;
            r_sum    <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d     <= n_d;
        r_last  <= n_last;
        r_col   <= n_col;
        r_row   <= n_row;
        r_cnt   <= n_cnt;
        r_div   <= n_div;
        r_rem   <= n_rem;
        r_inbit <= n_inbit;
        r_q     <= n_q;
        r_w     <= n_w;
        r_res   <= n_res;
    end

    // -----------------------------------------------------------------------
    // Sequencer: next state and datapath control.
    // -----------------------------------------------------------------------
    always_comb begin
        logic                      row_done;
        logic                      emit_final;
        logic [idw_pkg::RAW_W-1:0] col_raw;
        logic                      col_done;

        n_state  = r_state;
        n_min    = r_min;
        n_count  = r_count;
        n_coinc  = r_coinc;
        n_sum    = r_sum;
        n_strobe = 1'b0;
        n_d      = r_d;
        n_last   = r_last;
        n_col    = r_col;
        n_row    = r_row;
        n_cnt    = r_cnt;
        n_div    = r_div;
        n_rem    = r_rem;
        n_inbit  = r_inbit;
        n_q      = r_q;
        n_w      = r_w;
        n_res    = r_res;

        ram_we    = 1'b0;
        ram_waddr = {r_count[idw_pkg::ROW_IDX_W-1:0], r_col};
        ram_wdata = idw_pkg::RAW_ONE;

        row_done   = 1'b0;
        col_done   = 1'b0;
        col_raw    = idw_pkg::RAW_ONE;
        emit_final = (idw_pkg::ROW_W'({1'b0, r_row}) == r_count - idw_pkg::ROW_W'(1));

        // Configuration is taken only while idle, so a row in progress keeps
        // the threshold it started with.
        if (i_cfg_valid && r_state == idw_pkg::S_IDLE) begin
            n_min = i_cfg_data;
        end

        case (r_state)
            idw_pkg::S_IDLE: begin
                if (start) begin
                    n_d[0] = i_cmd.dist_euclid;
                    n_d[1] = i_cmd.dist_x;
                    n_d[2] = i_cmd.dist_y;
                    n_d[3] = i_cmd.dist_z;
                    n_last = i_cmd.last_row;
                    n_col  = '0;
                    n_row  = '0;
                    if (r_count < idw_pkg::ROW_W'(idw_pkg::MAX_ROWS)) begin
                        // A threshold written in the same cycle already
                        // applies to this row.
                        if (r_count == '0 && i_cmd.dist_euclid < n_min) begin
                            n_coinc = 1'b1;
                        end
                        n_state = idw_pkg::S_COL;
                    end else if (i_cmd.last_row) begin
                        // A dropped row that closes the set still releases it.
                        n_state = r_coinc ? idw_pkg::S_CEMIT : idw_pkg::S_NREAD;
                    end
                end
            end

            idw_pkg::S_COL: begin
                if (r_d[r_col] > r_min) begin
                    n_rem   = '0;
                    n_inbit = 1'b1;
                    n_div   = idw_pkg::SUM_W'(r_d[r_col]);
                    n_cnt   = idw_pkg::CNT_W'(idw_pkg::RECIP_STEPS - 1);
                    n_state = idw_pkg::S_RDIV;
                end else begin
                    col_raw  = idw_pkg::RAW_ONE;
                    col_done = 1'b1;
                end
            end

            idw_pkg::S_RDIV: begin
                n_rem   = step_rem;
                n_q     = step_q;
                n_inbit = 1'b0;
                n_cnt   = r_cnt - idw_pkg::CNT_W'(1);
                if (r_cnt == '0) begin
                    col_raw  = recip_raw;
                    col_done = 1'b1;
                end
            end

            idw_pkg::S_NREAD: begin
                n_state = idw_pkg::S_NLOAD;
            end

            idw_pkg::S_NLOAD: begin
                n_rem   = idw_pkg::SUM_W'(ram_rdata >> 1);
                n_inbit = ram_rdata[0];
                n_div   = r_sum[r_col];
                n_cnt   = idw_pkg::CNT_W'(idw_pkg::NORM_STEPS - 1);
                n_state = idw_pkg::S_NDIV;
            end

            idw_pkg::S_NDIV: begin
                n_rem   = step_rem;
                n_q     = step_q;
                n_inbit = 1'b0;
                n_cnt   = r_cnt - idw_pkg::CNT_W'(1);
                if (r_cnt == '0) begin
                    n_w[r_col] = norm_w;
                    if (r_col == idw_pkg::COL_W'(idw_pkg::NCOLS - 1)) begin
                        n_res.weight_euclid    = r_w[0];
                        n_res.weight_x         = r_w[1];
                        n_res.weight_y         = r_w[2];
                        n_res.weight_z         = norm_w;
                        n_res.final_weight_row = emit_final;
                        n_strobe               = 1'b1;
                        n_col                  = '0;
                        if (emit_final) begin
                            row_done = 1'b1;
                        end else begin
                            n_row   = r_row + idw_pkg::ROW_IDX_W'(1);
                            n_state = idw_pkg::S_NREAD;
                        end
                    end else begin
                        n_col   = r_col + idw_pkg::COL_W'(1);
                        n_state = idw_pkg::S_NREAD;
                    end
                end
            end

            idw_pkg::S_CEMIT: begin
                // Coincident set: the first row takes the whole weight.
                n_res.weight_euclid    = (r_row == '0) ? idw_pkg::WEIGHT_ONE : '0;
                n_res.weight_x         = (r_row == '0) ? idw_pkg::WEIGHT_ONE : '0;
                n_res.weight_y         = (r_row == '0) ? idw_pkg::WEIGHT_ONE : '0;
                n_res.weight_z         = (r_row == '0) ? idw_pkg::WEIGHT_ONE : '0;
                n_res.final_weight_row = emit_final;
                n_strobe               = 1'b1;
                if (emit_final) begin
                    row_done = 1'b1;
                end else begin
                    n_row = r_row + idw_pkg::ROW_IDX_W'(1);
                end
            end

            default: begin
                n_state = idw_pkg::S_IDLE;
            end
        endcase

        // A column's raw weight is ready: store it and add it to its sum.
        if (col_done) begin
            ram_we       = 1'b1;
            ram_wdata    = col_raw;
            n_sum[r_col] = r_sum[r_col] + idw_pkg::SUM_W'(col_raw);
            if (r_col == idw_pkg::COL_W'(idw_pkg::NCOLS - 1)) begin
                n_count = r_count + idw_pkg::ROW_W'(1);
                n_col   = '0;
                if (r_last) begin
                    n_state = r_coinc ? idw_pkg::S_CEMIT : idw_pkg::S_NREAD;
                end else begin
                    n_state = idw_pkg::S_IDLE;
                end
            end else begin
                n_col   = r_col + idw_pkg::COL_W'(1);
                n_state = idw_pkg::S_COL;
            end
        end

        // The last result of a set has gone out: start a fresh set.
        if (row_done) begin
            n_count = '0;
            n_coinc = 1'b0;
            for (int c = 0; c < idw_pkg::NCOLS; c++) begin
                n_sum[c] = '0;
            end
            n_state = idw_pkg::S_IDLE;
        end
    end

    assign busy         = (r_state != idw_pkg::S_IDLE);
    assign o_res        = r_res;
    assign o_res_strobe = r_strobe;
    assign o_cfg_ready  = (r_state == idw_pkg::S_IDLE);

endmodule

FILE: hdl/idw_checker.sv
// ---------------------------------------------------------------------------
// idw_checker: port-level checks for the inverse distance weights core
// Watches the command, result and busy ports over time.
// ---------------------------------------------------------------------------
module idw_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  idw_pkg::t_weights          o_res,
    input  logic                       o_res_strobe
);

    // Results only come out of a set that was being worked on.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(busy))
        else $error("result strobe without preceding busy cycle");

    // The final result of a set releases the block; earlier ones do not.
    a_final_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> (o_res.final_weight_row == !busy))
        else $error("final result flag does not match busy");

    // A freshly accepted row never brings a result in the very next cycle.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_res_strobe)
        else $error("result strobe straight after an accepted row");

    // Normalised weights never exceed one.
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> (o_res.weight_euclid <= idw_pkg::WEIGHT_ONE
                       && o_res.weight_x <= idw_pkg::WEIGHT_ONE
                       && o_res.weight_y <= idw_pkg::WEIGHT_ONE
                       && o_res.weight_z <= idw_pkg::WEIGHT_ONE))
        else $error("weight above one");

endmodule

bind inverse_distance_weights_core idw_checker u_idw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res        (o_res),
    .o_res_strobe (o_res_strobe)
);
